### src/lmfsd_pkg.sv
// Shared types, constants and lookup tables for the LED matrix scan driver.
// No dependencies; the top level, controller and datapath refer to this package by scoped names.
`default_nettype none

package lmfsd_pkg;

    // Panel geometry.
    localparam int PANEL_WIDTH  = 32;
    localparam int PANEL_HEIGHT = 32;
    localparam int SCAN_ROWS    = 16;

    // Derived widths. The store is addressed as {row, column}.
    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int CNT_W     = $clog2(PANEL_WIDTH + 1);
    localparam int ROW_W     = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int Y_TABLE_N = 64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SCAN  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    localparam logic KIND_SHIFT = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_px;
        logic sweep;
        logic load_col;
        logic load_latch;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic sweep_last;
        logic col_done;
        logic out_free;
    } dp_status_t;

    // Row within the scan for every non-negative y, worked out at elaboration.
    typedef logic [ROW_W-1:0] row_table_t [Y_TABLE_N];

    function automatic row_table_t build_row_table();
        row_table_t t;
        for (int i = 0; i < Y_TABLE_N; i++) begin
            t[i] = ROW_W'(i % SCAN_ROWS);
        end
        return t;
    endfunction

    localparam row_table_t ROW_TABLE = build_row_table();

endpackage

`default_nettype wire

### src/lmfsd_in_if.sv
// Input channel interface: pixel, clear and scan commands.
// Depends on nothing; field widths follow the command format.
`default_nettype none

interface lmfsd_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [6:0] pos_x;
    logic signed [6:0] pos_y;
    logic [2:0]        color;

    modport source (output valid, opcode, pos_x, pos_y, color, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, color, output ready);
endinterface

`default_nettype wire

### src/lmfsd_out_if.sv
// Output channel interface: column shift and row latch transactions.
// Depends on nothing; field widths follow the panel pin format.
`default_nettype none

interface lmfsd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic [3:0] row_address;
    logic       last;

    modport source (output valid, kind, upper_rgb, lower_rgb, row_address, last,
                    input ready);
    modport sink   (input valid, kind, upper_rgb, lower_rgb, row_address, last,
                    output ready);
endinterface

`default_nettype wire

### src/led_matrix_frame_scan_driver.sv
// Top level of the LED matrix frame store and row scan driver.
// Depends on lmfsd_pkg, lmfsd_in_if, lmfsd_out_if, lmfsd_ctrl and lmfsd_datapath.
//
//   Channel    Direction  Carries
//   pixel_in   sink       opcode, pos_x, pos_y, color (write, clear, scan)
//   scan_out   source     kind, upper_rgb, lower_rgb, row_address, last
//
// Pixel writes can be accepted on every cycle while no clear or scan is running.
// A clear sweeps all MEM_DEPTH store entries (512 here), zeroing one entry
// per cycle. After reset the same clearing pass runs before the first
// transaction is accepted. A scan takes PANEL_WIDTH + 1 output transactions,
// one per cycle through the single output register; a stalled output holds the
// scan and the input stays not ready until the latch is loaded.
`default_nettype none

module led_matrix_frame_scan_driver (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lmfsd_in_if.sink     pixel_in,
    lmfsd_out_if.source  scan_out
);

    lmfsd_pkg::ctrl_cmd_t  cmd;
    lmfsd_pkg::dp_status_t status;

    lmfsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .opcode   (pixel_in.opcode),
        .in_ready (pixel_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lmfsd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pos_x     (pixel_in.pos_x),
        .pos_y     (pixel_in.pos_y),
        .color     (pixel_in.color),
        .out_valid (scan_out.valid),
        .out_ready (scan_out.ready),
        .out_kind  (scan_out.kind),
        .out_upper (scan_out.upper_rgb),
        .out_lower (scan_out.lower_rgb),
        .out_row   (scan_out.row_address),
        .out_last  (scan_out.last)
    );

`ifndef SYNTHESIS
    // No transaction is taken while the store is being swept.
    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> !pixel_in.ready)
        else $error("input ready during clearing sweep");

    // Store write, sweep and output loads are mutually exclusive.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write_px, cmd.sweep, cmd.load_col, cmd.load_latch}))
        else $error("conflicting datapath commands");

    // An output load only happens when the output register is free.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_col || cmd.load_latch) |-> (!scan_out.valid || scan_out.ready))
        else $error("output register overwritten while stalled");

    // A latch transaction always ends the run and carries no color.
    a_latch_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_out.valid && scan_out.kind == lmfsd_pkg::KIND_LATCH) |->
            (scan_out.last && scan_out.upper_rgb == 3'd0 && scan_out.lower_rgb == 3'd0))
        else $error("malformed latch transaction");
`endif

endmodule

`default_nettype wire

### src/lmfsd_ctrl.sv
// Controller state machine: clearing sweep, command decode and scan sequencing.
// Depends on lmfsd_pkg for the state, opcode, command and status types.
`default_nettype none

module lmfsd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [1:0]             opcode,
    output logic                        in_ready,
    input  wire lmfsd_pkg::dp_status_t  status,
    output lmfsd_pkg::ctrl_cmd_t        cmd
);

    lmfsd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmfsd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            lmfsd_pkg::ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = lmfsd_pkg::ST_IDLE;
                end
            end
            lmfsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (opcode)
                        lmfsd_pkg::OP_WRITE: cmd.write_px = 1'b1;
                        lmfsd_pkg::OP_CLEAR: state_next = lmfsd_pkg::ST_CLEAR;
                        lmfsd_pkg::OP_SCAN:  state_next = lmfsd_pkg::ST_SCAN;
                        default:             state_next = lmfsd_pkg::ST_IDLE;
                    endcase
                end
            end
            lmfsd_pkg::ST_SCAN:
            begin
                // One column per free output slot, then the latch ends the row.
                if (status.out_free)
                begin
                    if (!status.col_done)
                    begin
                        cmd.load_col = 1'b1;
                    end
                    else
                    begin
                        cmd.load_latch = 1'b1;
                        state_next     = lmfsd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lmfsd_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lmfsd_datapath.sv
// Datapath: split frame store, scan row and column counters, output register.
// Depends on lmfsd_pkg for geometry, the row table and the command structs.
`default_nettype none

module lmfsd_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lmfsd_pkg::ctrl_cmd_t  cmd,
    output lmfsd_pkg::dp_status_t      status,
    input  wire logic signed [6:0]     pos_x,
    input  wire logic signed [6:0]     pos_y,
    input  wire logic [2:0]            color,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_kind,
    output logic [2:0]                 out_upper,
    output logic [2:0]                 out_lower,
    output logic [3:0]                 out_row,
    output logic                       out_last
);

    // Upper and lower halves are kept in separate arrays so a pixel write
    // touches only its own half without a read-modify-write.
    logic [2:0] upper_mem [lmfsd_pkg::MEM_DEPTH];
    logic [2:0] lower_mem [lmfsd_pkg::MEM_DEPTH];

    logic [lmfsd_pkg::ADDR_W-1:0] sweep_reg, sweep_next;
    logic [lmfsd_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [lmfsd_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                         out_valid_reg, out_valid_next;

    logic [2:0] upper_reg, lower_reg;
    logic [3:0] row_addr_reg;
    logic       kind_reg, last_reg;

    logic                         x_ok, y_ok, write_ok, y_upper;
    logic [lmfsd_pkg::ROW_W-1:0]  wr_row;
    logic [lmfsd_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic                         we_upper, we_lower;
    logic [2:0]                   wr_data;
    logic                         out_free;

    assign x_ok     = !pos_x[6] && (pos_x[5:0] < 6'(lmfsd_pkg::PANEL_WIDTH));
    assign y_ok     = !pos_y[6] && (pos_y[5:0] < 6'(lmfsd_pkg::PANEL_HEIGHT));
    assign write_ok = cmd.write_px && x_ok && y_ok;
    assign y_upper  = pos_y[5:0] < 6'(lmfsd_pkg::SCAN_ROWS);
    assign wr_row   = lmfsd_pkg::ROW_TABLE[pos_y[5:0]];

    always_comb
    begin
        if (cmd.sweep)
        begin
            wr_addr  = sweep_reg;
            wr_data  = 3'd0;
            we_upper = 1'b1;
            we_lower = 1'b1;
        end
        else
        begin
            wr_addr  = {wr_row, pos_x[lmfsd_pkg::COL_W-1:0]};
            wr_data  = color;
            we_upper = write_ok && y_upper;
            we_lower = write_ok && !y_upper;
        end
    end

    assign rd_addr  = {row_reg, col_reg[lmfsd_pkg::COL_W-1:0]};
    assign out_free = !out_valid_reg || out_ready;

    assign status.sweep_last = &sweep_reg;
    assign status.col_done   = col_reg == lmfsd_pkg::CNT_W'(lmfsd_pkg::PANEL_WIDTH);
    assign status.out_free   = out_free;

    always_comb
    begin
        sweep_next     = cmd.sweep ? sweep_reg + 1'b1 : sweep_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_col)
        begin
            col_next       = col_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        if (cmd.load_latch)
        begin
            col_next       = '0;
            out_valid_next = 1'b1;
            if (row_reg == lmfsd_pkg::ROW_W'(lmfsd_pkg::SCAN_ROWS - 1))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Store writes and the registered read into the output stage.
    always_ff @(posedge clk)
    begin
        if (we_upper)
        begin
            upper_mem[wr_addr] <= wr_data;
        end
        if (we_lower)
        begin
            lower_mem[wr_addr] <= wr_data;
        end
        if (cmd.load_col)
        begin
            upper_reg    <= upper_mem[rd_addr];
            lower_reg    <= lower_mem[rd_addr];
            kind_reg     <= lmfsd_pkg::KIND_SHIFT;
            row_addr_reg <= 4'd0;
            last_reg     <= 1'b0;
        end
        else if (cmd.load_latch)
        begin
            upper_reg    <= 3'd0;
            lower_reg    <= 3'd0;
            kind_reg     <= lmfsd_pkg::KIND_LATCH;
            row_addr_reg <= 4'(row_reg);
            last_reg     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_upper = upper_reg;
    assign out_lower = lower_reg;
    assign out_row   = row_addr_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire
